// File: hdl/packet_ring_queue_defines.svh
// Assertion macros shared by the packet ring queue RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef PACKET_RING_QUEUE_DEFINES_SVH
`define PACKET_RING_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PRQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PRQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/prq_pkg.sv
// Shared constants for the packet ring queue: geometry, opcodes, status codes.
// Depends on nothing; imported by the queue top level.
`default_nettype none

package prq_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_SIZE  = 64;

   localparam int IDX_W   = $clog2(SLOT_COUNT);
   localparam int OFS_W   = 7;
   localparam int BYTES   = SLOT_COUNT * SLOT_SIZE;
   localparam int ADDR_W  = $clog2(BYTES);

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_TAKE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_TOO_LONG = 2'd3;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [OFS_W-1:0]  ofs_type;
   typedef logic [ADDR_W-1:0] addr_type;

endpackage

`default_nettype wire

// File: hdl/prq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Read data holds its value while no read is enabled. No package dependency.
`default_nettype none

module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hdl/packet_ring_queue.sv
// Packet ring queue top level: control, ring pointers, result register.
// Depends on prq_pkg, prq_ram and packet_ring_queue_defines.svh.
`default_nettype none
`include "packet_ring_queue_defines.svh"

// The queue holds SLOT_COUNT packet slots of SLOT_SIZE bytes in a byte RAM,
// with each committed packet's length in a small length RAM; one slot always
// stays free so a full ring can be told from an empty one. Push, clear, no-op
// and a take on an empty ring complete on acceptance, so such beats can be
// accepted back to back while the result register drains. A take of a packet
// first reads the length RAM, then latches and clamps the length; a
// zero-length packet then gives a single result beat, and otherwise the byte
// RAM's registered read port delivers one byte per cycle into the result
// register while rsp_ready stays high. A result beat that waits for rsp_ready
// holds the byte stream back until it is taken. The result register sits
// between the sides, but req_ready follows rsp_ready in the same cycle: a new
// request beat is taken only when the result register is empty or hands its
// beat over at that same edge, so a stalled consumer stalls the request side.
// A pop advances the tail at the request, so every result beat of a pop
// already reports the queue-empty flag of the ring after the pop. No clearing
// pass follows reset: the memories are only read at entries a committed push
// has written.
module packet_ring_queue (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_packet,
   input  wire logic       req_empty_packet,
   input  wire logic       req_keep_entry,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [1:0] rsp_status,
   output logic      [7:0] rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_run_last,
   output logic            rsp_queue_empty
);

   import prq_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LEN    = 2'd1;
   localparam logic [1:0] S_STREAM = 2'd2;

   localparam idx_type LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam ofs_type SIZE_OFS = OFS_W'(SLOT_SIZE);

   // Control state.
   logic [1:0] state_ff, state_in;
   idx_type    head_ff, head_in;
   idx_type    tail_ff, tail_in;
   ofs_type    wr_ofs_ff, wr_ofs_in;
   logic       ovf_ff, ovf_in;
   ofs_type    len_ff, len_in;
   ofs_type    rd_cnt_ff, rd_cnt_in;
   logic       pend_ff, pend_in;
   logic       pend_last_ff, pend_last_in;
   addr_type   base_ff, base_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_bv_ff, rsp_bv_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_qe_ff, rsp_qe_in;

   // Memory ports.
   logic       byte_we, byte_re;
   addr_type   byte_waddr, byte_raddr;
   logic [7:0] byte_rdata;
   logic       len_we, len_re;
   ofs_type    len_wdata, len_rdata;

   logic       rsp_free, accept, load_now, issue;
   logic       stores, fits;
   idx_type    head_next, tail_next;
   ofs_type    ofs_after, len_clamp;
   logic       ovf_after;

   // The result register can take a new beat when it is empty or draining.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;

   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + IDX_W'(1);

   // A push byte is kept unless it is the discarded byte of a last beat that
   // marks its packet as ending before it. It fits while the slot has room.
   assign stores    = !(req_end_of_packet && req_empty_packet);
   assign fits      = wr_ofs_ff < SIZE_OFS;
   assign ofs_after = wr_ofs_ff + OFS_W'(stores && fits);
   assign ovf_after = ovf_ff || (stores && !fits);

   assign byte_waddr = ADDR_W'(int'(head_ff) * SLOT_SIZE + int'(wr_ofs_ff));
   assign byte_we    = accept && (req_opcode == OP_PUSH) && stores && fits;

   // Stored lengths never exceed a slot, but the clamp keeps a take bounded.
   assign len_clamp = (len_rdata > SIZE_OFS) ? SIZE_OFS : len_rdata;

   // Streaming: a byte read is issued when the RAM output holds no pending byte
   // or that byte is loaded into the result register now, so one byte moves per
   // cycle when the consumer keeps up and the RAM output simply holds while it stalls.
   assign load_now   = (state_ff == S_STREAM) && pend_ff && rsp_free;
   assign issue      = (state_ff == S_STREAM) && (len_ff != '0) && (rd_cnt_ff < len_ff)
                       && (!pend_ff || load_now);
   assign byte_re    = issue;
   assign byte_raddr = base_ff + ADDR_W'(rd_cnt_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      wr_ofs_in     = wr_ofs_ff;
      ovf_in        = ovf_ff;
      len_in        = len_ff;
      rd_cnt_in     = rd_cnt_ff;
      pend_in       = pend_ff;
      pend_last_in  = pend_last_ff;
      base_in       = base_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bv_in     = rsp_bv_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_qe_in     = rsp_qe_ff;
      len_we        = 1'b0;
      len_wdata     = ofs_after;
      len_re        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_byte_in   = '0;
               rsp_bv_in     = 1'b0;
               rsp_last_in   = 1'b1;
               case (req_opcode)
                  OP_PUSH: begin
                     if (req_end_of_packet) begin
                        if (ovf_after) begin
                           rsp_status_in = ST_TOO_LONG;
                        end else if (head_next == tail_ff) begin
                           rsp_status_in = ST_FULL;
                        end else begin
                           len_we  = 1'b1;
                           head_in = head_next;
                        end
                        wr_ofs_in = '0;
                        ovf_in    = 1'b0;
                     end else begin
                        wr_ofs_in = ofs_after;
                        ovf_in    = ovf_after;
                     end
                  end
                  OP_TAKE: begin
                     if (head_ff == tail_ff) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        // The result beats come later from the stream state.
                        rsp_valid_in = 1'b0;
                        len_re       = 1'b1;
                        base_in      = ADDR_W'(int'(tail_ff) * SLOT_SIZE);
                        state_in     = S_LEN;
                        if (!req_keep_entry) begin
                           tail_in = tail_next;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     tail_in   = head_ff;
                     wr_ofs_in = '0;
                     ovf_in    = 1'b0;
                  end
                  default: begin
                  end
               endcase
               rsp_qe_in = (head_in == tail_in);
            end
         end
         S_LEN: begin
            len_in    = len_clamp;
            rd_cnt_in = '0;
            pend_in   = 1'b0;
            state_in  = S_STREAM;
         end
         S_STREAM: begin
            if (len_ff == '0) begin
               if (rsp_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_byte_in   = '0;
                  rsp_bv_in     = 1'b0;
                  rsp_last_in   = 1'b1;
                  rsp_qe_in     = (head_ff == tail_ff);
                  state_in      = S_IDLE;
               end
            end else begin
               if (load_now) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_byte_in   = byte_rdata;
                  rsp_bv_in     = 1'b1;
                  rsp_last_in   = pend_last_ff;
                  rsp_qe_in     = (head_ff == tail_ff);
                  pend_in       = 1'b0;
                  if (pend_last_ff) begin
                     state_in = S_IDLE;
                  end
               end
               if (issue) begin
                  rd_cnt_in    = rd_cnt_ff + OFS_W'(1);
                  pend_in      = 1'b1;
                  pend_last_in = (rd_cnt_ff + OFS_W'(1)) == len_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         wr_ofs_ff    <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wr_ofs_ff    <= wr_ofs_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      rd_cnt_ff     <= rd_cnt_in;
      pend_last_ff  <= pend_last_in;
      base_ff       <= base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bv_ff     <= rsp_bv_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_qe_ff     <= rsp_qe_in;
   end

   // Packet bytes, one slot after another.
   prq_ram #(
      .WIDTH (8),
      .DEPTH (BYTES)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (byte_waddr),
      .wr_data (req_data_byte),
      .rd_en   (byte_re),
      .rd_addr (byte_raddr),
      .rd_data (byte_rdata)
   );

   // Committed packet lengths, written at head and read at tail.
   prq_ram #(
      .WIDTH (OFS_W),
      .DEPTH (SLOT_COUNT)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (head_ff),
      .wr_data (len_wdata),
      .rd_en   (len_re),
      .rd_addr (tail_ff),
      .rd_data (len_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_byte_valid  = rsp_bv_ff;
   assign rsp_run_last    = rsp_last_ff;
   assign rsp_queue_empty = rsp_qe_ff;

   `PRQ_ASSERT_IMP(a_ovf_only_when_full, clock, reset, ovf_ff, wr_ofs_ff == SIZE_OFS, "overflow flag set while slot has room")
   `PRQ_ASSERT_IMP(a_pend_in_stream, clock, reset, pend_ff, state_ff == S_STREAM, "pending byte outside stream state")
   `PRQ_ASSERT_NXT(a_issue_pends, clock, reset, issue, pend_ff, "issued byte read not pending")
   `PRQ_ASSERT_IMP(a_count_bounded, clock, reset, state_ff == S_STREAM, rd_cnt_ff <= len_ff, "read count beyond packet length")
   `PRQ_ASSERT_IMP(a_wr_ofs_bounded, clock, reset, 1'b1, wr_ofs_ff <= SIZE_OFS, "write offset beyond slot")

endmodule

`default_nettype wire
